@@ rtl/rlpf_pkg.sv @@
// Package with the types, constants and helper functions of the RGB light pattern fader.
`default_nettype none

package rlpf_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int FADE_STEPS  = 200;
    localparam int PCT_W       = 7;
    localparam int LEVEL_W     = PCT_W + FRAC_BITS;
    localparam int HOLD_W      = 16;
    localparam int DUTY_W      = 10;
    localparam int PRESET_W    = 3;
    localparam int NUM_CH      = 3;

    localparam int STEP_SHIFT  = LEVEL_W + $clog2(FADE_STEPS);
    localparam int MUL_W       = LEVEL_W + 1;
    localparam int PROD_W      = LEVEL_W + MUL_W;
    localparam int SCALE_W     = LEVEL_W + 4;
    localparam int ROUND_W     = SCALE_W - FRAC_BITS;

    localparam logic [63:0] STEP_MUL_FULL =
        ((64'd1 << STEP_SHIFT) + 64'(FADE_STEPS) - 64'd1) / 64'(FADE_STEPS);
    localparam logic [MUL_W-1:0] STEP_MUL = STEP_MUL_FULL[MUL_W-1:0];

    localparam logic [LEVEL_W-1:0] MIN_DIST   = LEVEL_W'((1 << FRAC_BITS) / 100);
    localparam logic [SCALE_W-1:0] ROUND_HALF = SCALE_W'(1) << (FRAC_BITS - 1);

    localparam logic [PCT_W-1:0]   MAX_PCT  = PCT_W'(100);
    localparam logic [DUTY_W-1:0]  DUTY_MAX = DUTY_W'(1000);
    localparam logic [PRESET_W-1:0] LAST_PRESET = PRESET_W'(5);

    localparam logic [HOLD_W-1:0] CYCLE_HOLD_RESET = HOLD_W'(800);
    localparam logic [HOLD_W-1:0] XMAS_HOLD_RESET  = HOLD_W'(3800);
    localparam logic [PCT_W-1:0]  MARGIN_RESET     = PCT_W'(5);
    localparam logic [PCT_W-1:0]  CUTOFF_RESET     = PCT_W'(10);

    typedef logic [PCT_W-1:0]   pct_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [DUTY_W-1:0]  duty_t;
    typedef logic [HOLD_W-1:0]  hold_t;
    typedef logic [PRESET_W-1:0] preset_t;

    typedef logic [NUM_CH-1:0][PCT_W-1:0]   rgb_pct_t;
    typedef logic [NUM_CH-1:0][LEVEL_W-1:0] rgb_level_t;
    typedef logic [NUM_CH-1:0][DUTY_W-1:0]  rgb_duty_t;

    typedef enum logic [2:0] {
        FUNC_TICK  = 3'd0,
        FUNC_SET   = 3'd1,
        FUNC_FADE  = 3'd2,
        FUNC_CYCLE = 3'd3,
        FUNC_XMAS  = 3'd4,
        FUNC_STOP  = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_FADE  = 2'd1,
        MODE_CYCLE = 2'd2,
        MODE_XMAS  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CFG_CYCLE_HOLD   = 2'd0,
        CFG_XMAS_HOLD    = 2'd1,
        CFG_CLOSE_MARGIN = 2'd2,
        CFG_DARK_CUTOFF  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [2:0] func;
        pct_t       red_in;
        pct_t       green_in;
        pct_t       blue_in;
    } cmd_t;

    typedef struct packed {
        duty_t      red_duty;
        duty_t      green_duty;
        duty_t      blue_duty;
        logic [1:0] mode_now;
    } res_t;

    typedef struct packed {
        hold_t cycle_hold_ticks;
        hold_t xmas_hold_ticks;
        pct_t  close_margin;
        pct_t  dark_cutoff;
    } cfg_t;

    function automatic rgb_pct_t rgb(input pct_t r, input pct_t g, input pct_t b);
        return {b, g, r};
    endfunction

    function automatic rgb_pct_t fade_color(input preset_t idx);
        rgb_pct_t c;
        case (idx)
            3'd0:    c = rgb(7'd100, 7'd0,   7'd0);
            3'd1:    c = rgb(7'd95,  7'd16,  7'd0);
            3'd2:    c = rgb(7'd95,  7'd41,  7'd0);
            3'd3:    c = rgb(7'd0,   7'd100, 7'd0);
            3'd4:    c = rgb(7'd0,   7'd0,   7'd100);
            3'd5:    c = rgb(7'd78,  7'd0,   7'd100);
            3'd6:    c = rgb(7'd100, 7'd0,   7'd0);
            default: c = rgb(7'd95,  7'd16,  7'd0);
        endcase
        return c;
    endfunction

    function automatic rgb_pct_t xmas_color(input logic sel);
        return sel ? rgb(7'd100, 7'd0, 7'd0) : rgb(7'd0, 7'd100, 7'd0);
    endfunction

    function automatic level_t pct_to_level(input pct_t p);
        return level_t'(p) << FRAC_BITS;
    endfunction

    function automatic rgb_level_t rgb_to_levels(input rgb_pct_t c);
        rgb_level_t l;
        for (int i = 0; i < NUM_CH; i++)
        begin
            l[i] = pct_to_level(c[i]);
        end
        return l;
    endfunction

    function automatic pct_t sat_pct(input pct_t p);
        return (p > MAX_PCT) ? MAX_PCT : p;
    endfunction

    function automatic level_t level_dist(input level_t a, input level_t b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Distance divided by the number of fade steps, by multiplication with
    // a rounded-up reciprocal that is exact over the whole level range; a distance below MIN_DIST gives a zero step.
    function automatic level_t step_from_dist(input level_t d);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(d) * PROD_W'(STEP_MUL);
        return (d < MIN_DIST) ? '0 : level_t'(prod >> STEP_SHIFT);
    endfunction

endpackage

`default_nettype wire

@@ rtl/rlpf_cmd_if.sv @@
// Command channel interface: valid, ready and one command item.
`default_nettype none

interface rlpf_cmd_if;
    logic              valid;
    logic              ready;
    rlpf_pkg::cmd_t    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/rlpf_res_if.sv @@
// Result channel interface: valid, ready and one duty result item.
`default_nettype none

interface rlpf_res_if;
    logic              valid;
    logic              ready;
    rlpf_pkg::res_t    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/rlpf_core.sv @@
// Pattern state: channel levels, fade steps, mode, preset and hold counter.
`default_nettype none

module rlpf_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire rlpf_pkg::cmd_t       cmd,
    input  wire rlpf_pkg::cfg_t       cfg,
    output rlpf_pkg::rgb_level_t      level_next,
    output rlpf_pkg::mode_t           mode_next
);

    rlpf_pkg::rgb_level_t level_reg;
    rlpf_pkg::rgb_level_t step_reg;
    rlpf_pkg::rgb_level_t step_next;
    rlpf_pkg::mode_t      mode_reg;
    rlpf_pkg::preset_t    preset_reg;
    rlpf_pkg::preset_t    preset_next;
    rlpf_pkg::hold_t      hold_reg;
    rlpf_pkg::hold_t      hold_next;

    rlpf_pkg::rgb_pct_t   fade_tgt;
    rlpf_pkg::rgb_pct_t   step_tgt;
    rlpf_pkg::rgb_level_t tgt_level;
    rlpf_pkg::rgb_level_t tick_level;
    rlpf_pkg::rgb_level_t step_base;
    rlpf_pkg::rgb_level_t new_step;
    rlpf_pkg::level_t     margin_level;
    logic [rlpf_pkg::NUM_CH-1:0] ch_close;
    logic                 all_close;
    logic                 start_fade;

    rlpf_pkg::preset_t    fade_preset_inc;
    logic                 xmas_sel_inc;
    rlpf_pkg::hold_t      hold_sel;
    rlpf_pkg::hold_t      hold_limit;
    logic [rlpf_pkg::HOLD_W:0] hold_inc;
    logic                 hold_done;

    assign start_fade      = (cmd.func == rlpf_pkg::FUNC_FADE);
    assign fade_tgt        = rlpf_pkg::fade_color(preset_reg);
    assign margin_level    = rlpf_pkg::pct_to_level(cfg.close_margin);
    assign fade_preset_inc = (preset_reg == rlpf_pkg::LAST_PRESET) ? '0 : preset_reg + 1'b1;
    assign xmas_sel_inc    = ~preset_reg[0];
    assign step_tgt        = start_fade ? rlpf_pkg::fade_color('0)
                                        : rlpf_pkg::fade_color(fade_preset_inc);

    assign hold_sel   = (mode_reg == rlpf_pkg::MODE_CYCLE) ? cfg.cycle_hold_ticks
                                                           : cfg.xmas_hold_ticks;
    assign hold_limit = (hold_sel == '0) ? rlpf_pkg::hold_t'(1) : hold_sel;
    assign hold_inc   = {1'b0, hold_reg} + 1'b1;
    assign hold_done  = (hold_inc >= {1'b0, hold_limit});

    for (genvar c = 0; c < rlpf_pkg::NUM_CH; c++)
    begin : g_ch
        rlpf_pkg::level_t cur_dist;

        assign tgt_level[c] = rlpf_pkg::pct_to_level(fade_tgt[c]);
        assign cur_dist     = rlpf_pkg::level_dist(level_reg[c], tgt_level[c]);

        always_comb
        begin
            if (cur_dist <= step_reg[c] || step_reg[c] == '0)
            begin
                tick_level[c] = tgt_level[c];
            end
            else if (level_reg[c] < tgt_level[c])
            begin
                tick_level[c] = level_reg[c] + step_reg[c];
            end
            else
            begin
                tick_level[c] = level_reg[c] - step_reg[c];
            end
        end

        assign ch_close[c]  = rlpf_pkg::level_dist(tick_level[c], tgt_level[c]) <= margin_level;
        assign step_base[c] = start_fade ? level_reg[c] : tick_level[c];
        assign new_step[c]  = rlpf_pkg::step_from_dist(
            rlpf_pkg::level_dist(step_base[c], rlpf_pkg::pct_to_level(step_tgt[c])));
    end

    assign all_close = &ch_close;

    always_comb
    begin
        level_next  = level_reg;
        step_next   = step_reg;
        mode_next   = mode_reg;
        preset_next = preset_reg;
        hold_next   = hold_reg;
        unique case (cmd.func)
            rlpf_pkg::FUNC_TICK:
            begin
                unique case (mode_reg)
                    rlpf_pkg::MODE_FADE:
                    begin
                        level_next = tick_level;
                        if (all_close)
                        begin
                            preset_next = fade_preset_inc;
                            step_next   = new_step;
                        end
                    end
                    rlpf_pkg::MODE_CYCLE:
                    begin
                        if (hold_done)
                        begin
                            hold_next   = '0;
                            preset_next = fade_preset_inc;
                            level_next  = rlpf_pkg::rgb_to_levels(
                                rlpf_pkg::fade_color(fade_preset_inc));
                        end
                        else
                        begin
                            hold_next = hold_inc[rlpf_pkg::HOLD_W-1:0];
                        end
                    end
                    rlpf_pkg::MODE_XMAS:
                    begin
                        if (hold_done)
                        begin
                            hold_next   = '0;
                            preset_next = rlpf_pkg::preset_t'(xmas_sel_inc);
                            level_next  = rlpf_pkg::rgb_to_levels(
                                rlpf_pkg::xmas_color(xmas_sel_inc));
                        end
                        else
                        begin
                            hold_next = hold_inc[rlpf_pkg::HOLD_W-1:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            rlpf_pkg::FUNC_SET:
            begin
                level_next = rlpf_pkg::rgb_to_levels(rlpf_pkg::rgb(
                    rlpf_pkg::sat_pct(cmd.red_in),
                    rlpf_pkg::sat_pct(cmd.green_in),
                    rlpf_pkg::sat_pct(cmd.blue_in)));
            end
            rlpf_pkg::FUNC_FADE:
            begin
                mode_next   = rlpf_pkg::MODE_FADE;
                preset_next = '0;
                hold_next   = '0;
                step_next   = new_step;
            end
            rlpf_pkg::FUNC_CYCLE:
            begin
                mode_next   = rlpf_pkg::MODE_CYCLE;
                preset_next = '0;
                hold_next   = '0;
                level_next  = rlpf_pkg::rgb_to_levels(rlpf_pkg::fade_color('0));
            end
            rlpf_pkg::FUNC_XMAS:
            begin
                mode_next   = rlpf_pkg::MODE_XMAS;
                preset_next = '0;
                hold_next   = '0;
                level_next  = rlpf_pkg::rgb_to_levels(rlpf_pkg::xmas_color(1'b0));
            end
            rlpf_pkg::FUNC_STOP:
            begin
                mode_next = rlpf_pkg::MODE_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg  <= '0;
            step_reg   <= '0;
            mode_reg   <= rlpf_pkg::MODE_IDLE;
            preset_reg <= '0;
            hold_reg   <= '0;
        end
        else if (advance)
        begin
            level_reg  <= level_next;
            step_reg   <= step_next;
            mode_reg   <= mode_next;
            preset_reg <= preset_next;
            hold_reg   <= hold_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rlpf_duty.sv @@
// Conversion of channel levels to rounded per-mille duty with the dark cutoff.
`default_nettype none

module rlpf_duty (
    input  wire rlpf_pkg::rgb_level_t level,
    input  wire rlpf_pkg::pct_t       dark_cutoff,
    output rlpf_pkg::rgb_duty_t       duty
);

    rlpf_pkg::level_t cutoff_level;

    assign cutoff_level = rlpf_pkg::pct_to_level(dark_cutoff);

    for (genvar c = 0; c < rlpf_pkg::NUM_CH; c++)
    begin : g_ch
        logic [rlpf_pkg::SCALE_W-1:0] scaled;
        logic [rlpf_pkg::ROUND_W-1:0] rounded;

        assign scaled  = (rlpf_pkg::SCALE_W'(level[c]) << 3)
                       + (rlpf_pkg::SCALE_W'(level[c]) << 1)
                       + rlpf_pkg::ROUND_HALF;
        assign rounded = rlpf_pkg::ROUND_W'(scaled >> rlpf_pkg::FRAC_BITS);

        always_comb
        begin
            if (level[c] < cutoff_level)
            begin
                duty[c] = '0;
            end
            else if (rounded > rlpf_pkg::ROUND_W'(rlpf_pkg::DUTY_MAX))
            begin
                duty[c] = rlpf_pkg::DUTY_MAX;
            end
            else
            begin
                duty[c] = rounded[rlpf_pkg::DUTY_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/rgb_led_pattern_fader.sv @@
// Top level of the RGB light pattern fader: channels, configuration and output register.
`default_nettype none

// Every command transfer yields exactly one result transfer. A command is
// registered on acceptance, processed by the pattern state logic once the
// result register is empty or is being read, and its result lands in the
// output register, from which it is offered. One command per cycle is taken
// as long as results are taken. The result register and the command register
// together let a new command in while a finished result still waits.
// Configuration writes go to the register given by cfg_index and should be
// made only while no command is in flight.

module rgb_led_pattern_fader (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    rlpf_cmd_if.sink                        cmd,
    rlpf_res_if.source                      result,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [rlpf_pkg::HOLD_W-1:0] cfg_wdata
);

    rlpf_pkg::cfg_t       cfg_reg;
    logic                 in_valid_reg;
    rlpf_pkg::cmd_t       in_data_reg;
    logic                 res_valid_reg;
    rlpf_pkg::res_t       res_data_reg;
    logic                 advance;
    rlpf_pkg::rgb_level_t level_next;
    rlpf_pkg::mode_t      mode_next;
    rlpf_pkg::rgb_duty_t  duty_next;

    assign advance      = in_valid_reg && (!res_valid_reg || result.ready);
    assign cmd.ready    = !in_valid_reg || advance;
    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cycle_hold_ticks <= rlpf_pkg::CYCLE_HOLD_RESET;
            cfg_reg.xmas_hold_ticks  <= rlpf_pkg::XMAS_HOLD_RESET;
            cfg_reg.close_margin     <= rlpf_pkg::MARGIN_RESET;
            cfg_reg.dark_cutoff      <= rlpf_pkg::CUTOFF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rlpf_pkg::CFG_CYCLE_HOLD:   cfg_reg.cycle_hold_ticks <= cfg_wdata;
                rlpf_pkg::CFG_XMAS_HOLD:    cfg_reg.xmas_hold_ticks  <= cfg_wdata;
                rlpf_pkg::CFG_CLOSE_MARGIN:
                    cfg_reg.close_margin <= cfg_wdata[rlpf_pkg::PCT_W-1:0];
                rlpf_pkg::CFG_DARK_CUTOFF:
                    cfg_reg.dark_cutoff  <= cfg_wdata[rlpf_pkg::PCT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_data_reg <= cmd.data;
        end
        if (advance)
        begin
            res_data_reg.red_duty   <= duty_next[0];
            res_data_reg.green_duty <= duty_next[1];
            res_data_reg.blue_duty  <= duty_next[2];
            res_data_reg.mode_now   <= mode_next;
        end
    end

    rlpf_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cmd        (in_data_reg),
        .cfg        (cfg_reg),
        .level_next (level_next),
        .mode_next  (mode_next)
    );

    rlpf_duty u_duty (
        .level       (level_next),
        .dark_cutoff (cfg_reg.dark_cutoff),
        .duty        (duty_next)
    );

endmodule

`default_nettype wire
